// ----- rtl/lzssbd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzssbd_pkg
// Shared widths and constants of the LZSS block decompressor: stream beat
// layout, token fields and defaults of the top-level parameters.
// ----------------------------------------------------------------------------
package lzssbd_pkg;

    // Defaults of the top-level parameters
    localparam int WINDOW_BYTES_DEF = 4096;
    localparam int LENGTH_BITS_DEF  = 24;

    // Stream beat layout
    localparam int BYTE_W      = 8;
    localparam int IN_TUSER_W  = 1;
    localparam int LEN_OUT_W   = 24;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 2;

    // Bits of the result tuser
    localparam int TU_BYTE_VALID = 0;
    localparam int TU_RUN_LAST   = 1;

    // Token format
    localparam int                OFF_W       = 12;
    localparam int                COPY_CNT_W  = 5;
    localparam int                FLAG_W      = 17;
    localparam logic [FLAG_W-1:0] FLAG_SENTINEL = 17'h10000;
    localparam logic [FLAG_W-1:0] FLAG_EMPTY    = 17'h00001;
    localparam logic [4:0]        MATCH_MIN   = 5'd3;
    localparam logic [7:0]        RAW_MARKER  = 8'h01;
    localparam logic [1:0]        HDR_LAST    = 2'd3;

endpackage

// ----- rtl/lzss_block_decompressor_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_block_decompressor_core
// LZSS block decompressor: 4-byte header, raw or flag-word coded blocks,
// 12-bit back offsets and 3..18 byte copies out of a history window memory.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                         | tuser              | tlast
//  ---------+-----+-------------------------------+--------------------+-------------
//  s_       | in  | in_byte                       | first_of_block     | last_of_block
//  m_       | out | out_byte, out_length, fmt err | byte_valid, run_lst| end_of_block
//
//  An input beat is held in an input register and parsed from there. A
//  match pair is followed by a copy of 3..18 bytes: the window memory gives
//  one byte a cycle through its single read port while m_tready allows. A
//  stall on m_tready holds the copy, and the input register still takes one
//  beat meanwhile. aresetn clears parser state, wp, copy count and m_tvalid;
//  the window, read pointer, copy flags and output beat are not cleared.
// ----------------------------------------------------------------------------
module lzss_block_decompressor_core #(
    parameter int WINDOW_BYTES = lzssbd_pkg::WINDOW_BYTES_DEF,
    parameter int LENGTH_BITS  = lzssbd_pkg::LENGTH_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // in_byte
    input  logic [lzssbd_pkg::BYTE_W-1:0]       s_tdata,
    // first_of_block
    input  logic [lzssbd_pkg::IN_TUSER_W-1:0]   s_tuser,
    input  logic                                s_tlast,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // out_byte [7:0], out_length [31:8], format_error [32], zero [39:33]
    output logic [lzssbd_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // byte_valid [0], run_last [1]
    output logic [lzssbd_pkg::OUT_TUSER_W-1:0]  m_tuser,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready
);
    import lzssbd_pkg::*;

    localparam int              AW   = $clog2(WINDOW_BYTES);
    localparam int              LW   = LENGTH_BITS;
    localparam logic [AW-1:0]   WEND = AW'(WINDOW_BYTES - 1);
    localparam logic [AW:0]     WLEN = (AW+1)'(WINDOW_BYTES);
    localparam logic [LW-1:0]   LMAX = {LW{1'b1}};

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_RAW,
        PH_TOKEN,
        PH_FLAG_HI,
        PH_MATCH_LO
    } phase_t;

    typedef enum logic {
        ST_PARSE,
        ST_COPY
    } state_t;

    // Input holding register
    logic                  in_full_reg, in_full_next;
    logic [BYTE_W-1:0]     in_byte_reg;
    logic                  in_first_reg, in_last_reg;

    // Parser state
    state_t                state_reg, state_next;
    phase_t                phase_reg, phase_next;
    logic [1:0]            hc_reg, hc_next;
    logic                  raw_reg, raw_next;
    logic [FLAG_W-1:0]     fs_reg, fs_next;
    logic [BYTE_W-1:0]     mh_reg, mh_next;
    logic [LW-1:0]         cnt_reg, cnt_next;
    logic                  err_reg, err_next;

    // Window pointers and copy control
    logic [AW-1:0]         wp_reg, wp_next;
    logic [AW-1:0]         rp_reg, rp_next;
    logic [COPY_CNT_W-1:0] copy_left_reg, copy_left_next;
    logic                  copy_one_reg, copy_one_next;
    logic                  copy_first_reg, copy_first_next;
    logic                  copy_end_reg, copy_end_next;
    logic [BYTE_W-1:0]     last_byte_reg, last_byte_next;

    // Output register
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [BYTE_W-1:0]     o_byte_reg, o_byte_next;
    logic                  o_valid_reg, o_valid_next;
    logic                  o_run_reg, o_run_next;
    logic                  o_end_reg, o_end_next;
    logic [LEN_OUT_W-1:0]  o_len_reg, o_len_next;
    logic                  o_err_reg, o_err_next;

    // Window memory
    logic [BYTE_W-1:0]     mem [WINDOW_BYTES];
    logic [BYTE_W-1:0]     rdata_reg;
    logic                  wr_en, rd_en;
    logic [AW-1:0]         rd_addr;
    logic [BYTE_W-1:0]     wr_data;

    // Parse helpers
    logic                  s_fire, can_load, proc_go, copy_go, out_load;
    logic                  blk_start, trunc, err_fin;
    phase_t                ph_cur;
    logic [1:0]            hc_cur;
    logic                  raw_cur;
    logic [FLAG_W-1:0]     fs_cur;
    logic [LW-1:0]         cnt_base, cnt_inc;
    logic [OFF_W-1:0]      off;
    logic [AW:0]           rd_start;
    logic [BYTE_W-1:0]     copy_byte;

    assign s_fire   = s_tvalid && s_tready;
    assign s_tready = !in_full_reg;
    assign can_load = !m_tvalid_reg || m_tready;
    assign proc_go  = (state_reg == ST_PARSE) && in_full_reg && can_load;
    assign copy_go  = (state_reg == ST_COPY) && can_load;

    // Block start forces the header phase
    assign blk_start = in_first_reg || (phase_reg == PH_HEADER && hc_reg == 2'd0);
    assign ph_cur    = blk_start ? PH_HEADER : phase_reg;
    assign hc_cur    = blk_start ? 2'd0 : hc_reg;
    assign raw_cur   = blk_start ? 1'b0 : raw_reg;
    assign fs_cur    = blk_start ? FLAG_EMPTY : fs_reg;
    assign cnt_base  = blk_start ? '0 : cnt_reg;
    assign cnt_inc   = (cnt_base == LMAX) ? cnt_base : cnt_base + 1'b1;

    // Match offset and first read address behind the write pointer
    assign off       = {mh_reg[7:4], in_byte_reg};
    assign rd_start  = ({1'b0, wp_reg} >= (AW+1)'(off))
                       ? ({1'b0, wp_reg} - (AW+1)'(off))
                       : ({1'b0, wp_reg} + WLEN - (AW+1)'(off));

    // Distance one repeats the byte just written, which the memory cannot
    // return yet: take it from the last-byte register instead
    assign copy_byte = (copy_first_reg || !copy_one_reg) ? rdata_reg : last_byte_reg;

    assign out_load  = m_tvalid_next && (!m_tvalid_reg || m_tready) &&
                       (proc_go || copy_go);

    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        hc_next         = hc_reg;
        raw_next        = raw_reg;
        fs_next         = fs_reg;
        mh_next         = mh_reg;
        cnt_next        = cnt_reg;
        err_next        = err_reg;
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        copy_left_next  = copy_left_reg;
        copy_one_next   = copy_one_reg;
        copy_first_next = copy_first_reg;
        copy_end_next   = copy_end_reg;
        last_byte_next  = last_byte_reg;
        o_byte_next     = o_byte_reg;
        o_valid_next    = o_valid_reg;
        o_run_next      = o_run_reg;
        o_end_next      = o_end_reg;
        o_len_next      = o_len_reg;
        o_err_next      = o_err_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        in_full_next    = s_fire ? 1'b1 : (proc_go ? 1'b0 : in_full_reg);
        wr_en           = 1'b0;
        wr_data         = in_byte_reg;
        rd_en           = 1'b0;
        rd_addr         = rp_reg;
        trunc           = 1'b0;
        err_fin         = err_reg;

        if (proc_go) begin
            // Parse one input byte
            phase_next = ph_cur;
            hc_next    = hc_cur;
            raw_next   = raw_cur;
            fs_next    = fs_cur;
            cnt_next   = cnt_base;
            err_next   = blk_start ? 1'b0 : err_reg;
            unique case (ph_cur)
                PH_HEADER: begin
                    if (hc_cur == 2'd0) begin
                        raw_next = (in_byte_reg == RAW_MARKER);
                    end
                    if (hc_cur == HDR_LAST) begin
                        hc_next    = 2'd0;
                        fs_next    = FLAG_EMPTY;
                        phase_next = raw_cur ? PH_RAW : PH_TOKEN;
                    end else begin
                        hc_next = hc_cur + 2'd1;
                    end
                end
                PH_RAW: begin
                    wr_en = 1'b1;
                end
                PH_TOKEN: begin
                    if (fs_cur <= FLAG_EMPTY) begin
                        fs_next    = FLAG_SENTINEL | FLAG_W'(in_byte_reg);
                        phase_next = PH_FLAG_HI;
                    end else if (!fs_cur[0]) begin
                        wr_en   = 1'b1;
                        fs_next = fs_cur >> 1;
                    end else begin
                        mh_next    = in_byte_reg;
                        phase_next = PH_MATCH_LO;
                    end
                end
                PH_FLAG_HI: begin
                    fs_next    = fs_cur | {1'b0, in_byte_reg, 8'h00};
                    phase_next = PH_TOKEN;
                end
                PH_MATCH_LO: begin
                    if (off == '0 || LW'(off) > cnt_base) begin
                        err_next = 1'b1;
                    end else begin
                        rd_en           = 1'b1;
                        rd_addr         = rd_start[AW-1:0];
                        rp_next         = (rd_start[AW-1:0] == WEND) ? '0
                                          : rd_start[AW-1:0] + 1'b1;
                        copy_left_next  = COPY_CNT_W'(mh_reg[3:0]) + MATCH_MIN;
                        copy_one_next   = (off == OFF_W'(1));
                        copy_first_next = 1'b1;
                        copy_end_next   = in_last_reg;
                        state_next      = ST_COPY;
                    end
                    fs_next    = fs_cur >> 1;
                    phase_next = PH_TOKEN;
                end
                default: begin
                    phase_next = PH_HEADER;
                    hc_next    = 2'd0;
                end
            endcase

            // End of block: flag a truncated token, rearm for a header
            trunc = (phase_next == PH_HEADER) || (phase_next == PH_FLAG_HI) ||
                    (phase_next == PH_MATCH_LO) ||
                    (phase_next == PH_TOKEN && fs_next[FLAG_W-1]);
            err_fin = err_next | (in_last_reg & trunc);
            if (in_last_reg) begin
                err_next   = err_fin;
                phase_next = PH_HEADER;
                hc_next    = 2'd0;
                raw_next   = 1'b0;
                fs_next    = FLAG_EMPTY;
            end

            // Load a literal or an end-only result
            if (wr_en) begin
                wp_next       = (wp_reg == WEND) ? '0 : wp_reg + 1'b1;
                cnt_next      = cnt_inc;
                m_tvalid_next = 1'b1;
                o_byte_next   = in_byte_reg;
                o_valid_next  = 1'b1;
                o_run_next    = 1'b1;
                o_end_next    = in_last_reg;
                o_len_next    = LEN_OUT_W'(cnt_inc);
                o_err_next    = err_fin;
            end else if (in_last_reg && state_next == ST_PARSE) begin
                m_tvalid_next = 1'b1;
                o_byte_next   = '0;
                o_valid_next  = 1'b0;
                o_run_next    = 1'b1;
                o_end_next    = 1'b1;
                o_len_next    = LEN_OUT_W'(cnt_base);
                o_err_next    = err_fin;
            end
        end else if (copy_go) begin
            // Emit one copied byte and read the next
            wr_en           = 1'b1;
            wr_data         = copy_byte;
            rd_en           = 1'b1;
            rd_addr         = rp_reg;
            rp_next         = (rp_reg == WEND) ? '0 : rp_reg + 1'b1;
            wp_next         = (wp_reg == WEND) ? '0 : wp_reg + 1'b1;
            cnt_next        = (cnt_reg == LMAX) ? cnt_reg : cnt_reg + 1'b1;
            last_byte_next  = copy_byte;
            copy_first_next = 1'b0;
            copy_left_next  = copy_left_reg - 1'b1;
            m_tvalid_next   = 1'b1;
            o_byte_next     = copy_byte;
            o_valid_next    = 1'b1;
            o_run_next      = (copy_left_reg == COPY_CNT_W'(1));
            o_end_next      = copy_end_reg && (copy_left_reg == COPY_CNT_W'(1));
            o_len_next      = LEN_OUT_W'(cnt_next);
            o_err_next      = err_reg;
            if (copy_left_reg == COPY_CNT_W'(1)) begin
                state_next = ST_PARSE;
            end
        end
    end

    // Window memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wp_reg] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_full_reg    <= 1'b0;
            state_reg      <= ST_PARSE;
            phase_reg      <= PH_HEADER;
            hc_reg         <= 2'd0;
            raw_reg        <= 1'b0;
            fs_reg         <= FLAG_EMPTY;
            mh_reg         <= '0;
            cnt_reg        <= '0;
            err_reg        <= 1'b0;
            wp_reg         <= '0;
            copy_left_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            in_full_reg    <= in_full_next;
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            hc_reg         <= hc_next;
            raw_reg        <= raw_next;
            fs_reg         <= fs_next;
            mh_reg         <= mh_next;
            cnt_reg        <= cnt_next;
            err_reg        <= err_next;
            wp_reg         <= wp_next;
            copy_left_reg  <= copy_left_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        if (s_fire) begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser[0];
            in_last_reg  <= s_tlast;
        end
        rp_reg         <= rp_next;
        copy_one_reg   <= copy_one_next;
        copy_first_reg <= copy_first_next;
        copy_end_reg   <= copy_end_next;
        last_byte_reg  <= last_byte_next;
        o_byte_reg     <= o_byte_next;
        o_valid_reg    <= o_valid_next;
        o_run_reg      <= o_run_next;
        o_end_reg      <= o_end_next;
        o_len_reg      <= o_len_next;
        o_err_reg      <= o_err_next;
    end

    // Drive the result beat
    assign m_tvalid                = m_tvalid_reg;
    assign m_tdata                 = {7'd0, o_err_reg, o_len_reg, o_byte_reg};
    assign m_tuser[TU_BYTE_VALID]  = o_valid_reg;
    assign m_tuser[TU_RUN_LAST]    = o_run_reg;
    assign m_tlast                 = o_end_reg;

`ifndef SYNTHESIS
    // A copy in progress always has bytes left
    a_copy_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY) |-> (copy_left_reg != '0))
        else $error("copy active with no bytes left");

    // Every window write goes out as a data beat, and only then
    a_write_out: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en == (out_load && o_valid_next))
        else $error("window write and data beat out of step");

    // End of block closes the run of its input byte
    a_end_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser[TU_RUN_LAST])
        else $error("end of block without run_last");

    // No input byte is parsed while a copy runs
    a_no_parse_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY) |-> !proc_go)
        else $error("input parsed during copy");
`endif

endmodule
